// File: sv/esm_pkg.sv
`default_nettype none

package esm_pkg;

	// Number formats
	localparam int FRAC_BITS  = 16;
	localparam int ANGLE_BITS = 16;

	// Port widths
	localparam int IN_W   = 240;
	localparam int OUT_W  = 96;
	localparam int USER_W = 4;

	// pi in Q2.30, used to map a folded turn fraction to radians
	localparam logic [31:0] PI_Q30 = 32'd3373259426;

	// Taylor series of sine and cosine: six terms after the first
	localparam int TAYLOR_STEPS = 6;
	localparam logic [63:0] RCP_BASE = 64'd1 << 32;
	localparam logic [7:0] SIN_DIV [TAYLOR_STEPS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
	localparam logic [7:0] COS_DIV [TAYLOR_STEPS] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
	localparam logic [31:0] SIN_RCP [TAYLOR_STEPS] = '{
		32'(RCP_BASE / 64'd6),  32'(RCP_BASE / 64'd20), 32'(RCP_BASE / 64'd42),
		32'(RCP_BASE / 64'd72), 32'(RCP_BASE / 64'd110), 32'(RCP_BASE / 64'd156)};
	localparam logic [31:0] COS_RCP [TAYLOR_STEPS] = '{
		32'(RCP_BASE / 64'd2),  32'(RCP_BASE / 64'd12), 32'(RCP_BASE / 64'd30),
		32'(RCP_BASE / 64'd56), 32'(RCP_BASE / 64'd90), 32'(RCP_BASE / 64'd132)};

	// Sine/cosine pipeline stages: fold, x and x^2, series start, three per series term, clamp
	localparam int TRIG_LAT = 3 + 3 * TAYLOR_STEPS + 1;

	// Reciprocal divider: two quotient bits per stage
	localparam int RCP_RAW_W = (2 * FRAC_BITS + 1 > 31) ? 2 * FRAC_BITS + 1 : 31;
	localparam int RCP_NUM_W = ((RCP_RAW_W + 1) / 2) * 2;
	localparam int RCP_STEPS = RCP_NUM_W / 2;
	localparam int RCP_LAT   = RCP_STEPS + 2;

	// Both units are padded to the common latency
	localparam int CORE_LAT = (TRIG_LAT > RCP_LAT) ? TRIG_LAT : RCP_LAT;
	localparam int SIDE_LAT = CORE_LAT + 3;
	localparam int PIPE_LAT = CORE_LAT + 4;

	// Output beats of one object
	localparam int BEAT_W = 3;
	localparam logic [BEAT_W-1:0] BEAT_FIRST  = 3'd0;
	localparam logic [BEAT_W-1:0] BEAT_OFFSET = 3'd3;
	localparam logic [BEAT_W-1:0] BEAT_NORMAL = 3'd4;
	localparam logic [BEAT_W-1:0] BEAT_LAST   = 3'd6;

	// Values that travel beside the trig units
	typedef struct packed {
		logic [2:0][31:0] scale;
		logic [2:0][31:0] offset;
		logic             fault;
	} side_t;

	// One finished object: model columns, translation, normal columns
	typedef struct packed {
		logic [2:0][2:0][31:0] model;
		logic [2:0][31:0]      offset;
		logic [2:0][2:0][31:0] normal;
		logic                  fault;
	} colset_t;

	// Round to nearest, ties away from zero, then drop 30 fraction bits
	function automatic logic signed [35:0] rnd30(input logic signed [65:0] p);
		logic signed [65:0] bias;
		bias = p[65] ? 66'sd536870911 : 66'sd536870912;
		return 36'((p + bias) >>> 30);
	endfunction

	function automatic logic signed [35:0] mul30(input logic signed [32:0] a,
		input logic signed [32:0] b);
		logic signed [65:0] p;
		p = a * b;
		return rnd30(p);
	endfunction

	function automatic logic [31:0] sat32(input logic signed [35:0] v);
		logic [31:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -36'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/esm_sincos.sv
`default_nettype none

module esm_sincos (
	input  logic                           clk,
	input  logic                           en,
	input  logic [esm_pkg::ANGLE_BITS-1:0] angle,
	output logic signed [31:0]             sin_val,
	output logic signed [31:0]             cos_val
);

	localparam int STEPS = esm_pkg::TAYLOR_STEPS;
	localparam int PAD   = esm_pkg::CORE_LAT - esm_pkg::TRIG_LAT;

	logic [31:0] turn;
	logic [29:0] fold;
	logic [2:0]  oct_s1;
	logic [61:0] prod_s1;
	logic [61:0] xr;
	logic [29:0] x_c;
	logic [29:0] x_s2;
	logic [59:0] xx_s2;
	logic [2:0]  oct_s2;
	logic [59:0] xxr;

	// Term stages: index 0 is the series start, index k the state after term k
	logic [30:0]        sterm_c [STEPS+1];
	logic [30:0]        cterm_c [STEPS+1];
	logic signed [32:0] ssum_c  [STEPS+1];
	logic signed [32:0] csum_c  [STEPS+1];
	logic [29:0]        x2_c    [STEPS+1];
	logic [2:0]         oct_c   [STEPS+1];

	logic [60:0]        sp_a   [STEPS];
	logic [60:0]        cp_a   [STEPS];
	logic signed [32:0] ssum_a [STEPS];
	logic signed [32:0] csum_a [STEPS];
	logic [29:0]        x2_a   [STEPS];
	logic [2:0]         oct_a  [STEPS];

	logic [30:0]        st_b   [STEPS];
	logic [30:0]        ct_b   [STEPS];
	logic [62:0]        sm_b   [STEPS];
	logic [62:0]        cm_b   [STEPS];
	logic signed [32:0] ssum_b [STEPS];
	logic signed [32:0] csum_b [STEPS];
	logic [29:0]        x2_b   [STEPS];
	logic [2:0]         oct_b  [STEPS];

	logic [30:0]        s_cl;
	logic [30:0]        c_cl;
	logic [30:0]        sv;
	logic [30:0]        cv;
	logic signed [31:0] sin_s22;
	logic signed [31:0] cos_s22;

	// Fold the turn into one octant
	assign turn = {angle, {(32 - esm_pkg::ANGLE_BITS){1'b0}}};
	assign fold = turn[29] ? (30'd1 << 29) - {1'b0, turn[28:0]} : {1'b0, turn[28:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			oct_s1  <= turn[31:29];
			prod_s1 <= 62'(fold) * 62'(esm_pkg::PI_Q30);
		end
	end

	// Radians and their square
	assign xr  = prod_s1 + (62'd1 << 30);
	assign x_c = xr[60:31];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2   <= x_c;
			xx_s2  <= 60'(x_c) * 60'(x_c);
			oct_s2 <= oct_s1;
		end
	end

	assign xxr = xx_s2 + (60'd1 << 29);

	always_ff @(posedge clk) begin
		if (en) begin
			sterm_c[0] <= 31'(x_s2);
			ssum_c[0]  <= $signed({3'b000, x_s2});
			cterm_c[0] <= 31'd1 << 30;
			csum_c[0]  <= 33'sd1073741824;
			x2_c[0]    <= xxr[59:30];
			oct_c[0]   <= oct_s2;
		end
	end

	// One series term per three stages: multiply, scale by reciprocal, correct
	for (genvar k = 0; k < STEPS; k++) begin : g_term
		logic [60:0] spr;
		logic [60:0] cpr;
		logic [30:0] st_n;
		logic [30:0] ct_n;
		logic [30:0] sq;
		logic [30:0] cq;
		logic [31:0] srem;
		logic [31:0] crem;
		logic [30:0] sq_fix;
		logic [30:0] cq_fix;

		always_ff @(posedge clk) begin
			if (en) begin
				sp_a[k]   <= 61'(sterm_c[k]) * 61'(x2_c[k]);
				cp_a[k]   <= 61'(cterm_c[k]) * 61'(x2_c[k]);
				ssum_a[k] <= ssum_c[k];
				csum_a[k] <= csum_c[k];
				x2_a[k]   <= x2_c[k];
				oct_a[k]  <= oct_c[k];
			end
		end

		assign spr  = sp_a[k] + (61'd1 << 29);
		assign cpr  = cp_a[k] + (61'd1 << 29);
		assign st_n = spr[60:30];
		assign ct_n = cpr[60:30];

		always_ff @(posedge clk) begin
			if (en) begin
				st_b[k]   <= st_n;
				ct_b[k]   <= ct_n;
				sm_b[k]   <= 63'(st_n) * 63'(esm_pkg::SIN_RCP[k]);
				cm_b[k]   <= 63'(ct_n) * 63'(esm_pkg::COS_RCP[k]);
				ssum_b[k] <= ssum_a[k];
				csum_b[k] <= csum_a[k];
				x2_b[k]   <= x2_a[k];
				oct_b[k]  <= oct_a[k];
			end
		end

		// Estimate is at most one short of the quotient
		assign sq     = sm_b[k][62:32];
		assign cq     = cm_b[k][62:32];
		assign srem   = {1'b0, st_b[k]} - 32'(sq) * 32'(esm_pkg::SIN_DIV[k]);
		assign crem   = {1'b0, ct_b[k]} - 32'(cq) * 32'(esm_pkg::COS_DIV[k]);
		assign sq_fix = (srem >= 32'(esm_pkg::SIN_DIV[k])) ? sq + 31'd1 : sq;
		assign cq_fix = (crem >= 32'(esm_pkg::COS_DIV[k])) ? cq + 31'd1 : cq;

		always_ff @(posedge clk) begin
			if (en) begin
				sterm_c[k+1] <= sq_fix;
				cterm_c[k+1] <= cq_fix;
				ssum_c[k+1]  <= ((k % 2) == 0) ? ssum_b[k] - $signed({2'b00, sq_fix})
				                               : ssum_b[k] + $signed({2'b00, sq_fix});
				csum_c[k+1]  <= ((k % 2) == 0) ? csum_b[k] - $signed({2'b00, cq_fix})
				                               : csum_b[k] + $signed({2'b00, cq_fix});
				x2_c[k+1]    <= x2_b[k];
				oct_c[k+1]   <= oct_b[k];
			end
		end
	end

	// Clamp to [0, 1] and unfold the octant
	always_comb begin
		if (ssum_c[STEPS] < 33'sd0) begin
			s_cl = 31'd0;
		end else if (ssum_c[STEPS] > 33'sd1073741824) begin
			s_cl = 31'd1 << 30;
		end else begin
			s_cl = ssum_c[STEPS][30:0];
		end
		if (csum_c[STEPS] < 33'sd0) begin
			c_cl = 31'd0;
		end else if (csum_c[STEPS] > 33'sd1073741824) begin
			c_cl = 31'd1 << 30;
		end else begin
			c_cl = csum_c[STEPS][30:0];
		end
		sv = (oct_c[STEPS][0] ^ oct_c[STEPS][1]) ? c_cl : s_cl;
		cv = (oct_c[STEPS][0] ^ oct_c[STEPS][1]) ? s_cl : c_cl;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_s22 <= oct_c[STEPS][2] ? -$signed({1'b0, sv}) : $signed({1'b0, sv});
			cos_s22 <= (oct_c[STEPS][1] ^ oct_c[STEPS][2]) ? -$signed({1'b0, cv})
			                                              : $signed({1'b0, cv});
		end
	end

	// Pad to the common unit latency
	if (PAD > 0) begin : g_pad
		logic signed [31:0] sin_p [PAD];
		logic signed [31:0] cos_p [PAD];

		always_ff @(posedge clk) begin
			if (en) begin
				sin_p[0] <= sin_s22;
				cos_p[0] <= cos_s22;
				for (int i = 1; i < PAD; i++) begin
					sin_p[i] <= sin_p[i-1];
					cos_p[i] <= cos_p[i-1];
				end
			end
		end

		assign sin_val = sin_p[PAD-1];
		assign cos_val = cos_p[PAD-1];
	end else begin : g_nopad
		assign sin_val = sin_s22;
		assign cos_val = cos_s22;
	end

endmodule

`default_nettype wire

// File: sv/esm_rcp.sv
`default_nettype none

module esm_rcp (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] scale,
	output logic signed [31:0] inv
);

	localparam int NW    = esm_pkg::RCP_NUM_W;
	localparam int STEPS = esm_pkg::RCP_STEPS;
	localparam int PAD   = esm_pkg::CORE_LAT - esm_pkg::RCP_LAT;

	logic [31:0] mag_c;

	logic [31:0]   rem_d  [STEPS];
	logic [NW-1:0] num_d  [STEPS];
	logic [31:0]   mag_d  [STEPS];
	logic [NW-1:0] quo_d  [STEPS+1];
	logic          neg_d  [STEPS+1];
	logic          zero_d [STEPS+1];

	logic signed [31:0] inv_r;

	// Magnitude and rounded numerator
	assign mag_c = scale[31] ? 32'(-scale) : 32'(scale);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_d[0]  <= mag_c;
			num_d[0]  <= (NW'(1) << (2 * esm_pkg::FRAC_BITS)) + NW'(mag_c >> 1);
			rem_d[0]  <= 32'd0;
			quo_d[0]  <= '0;
			neg_d[0]  <= scale[31];
			zero_d[0] <= (scale == 32'sd0);
		end
	end

	// Restoring division, two quotient bits per stage
	for (genvar j = 0; j < STEPS; j++) begin : g_div
		logic [32:0] t1;
		logic        ge1;
		logic [32:0] r1;
		logic [32:0] t2;
		logic        ge2;
		logic [32:0] r2;

		assign t1  = {rem_d[j], num_d[j][NW-1-2*j]};
		assign ge1 = t1 >= {1'b0, mag_d[j]};
		assign r1  = ge1 ? t1 - {1'b0, mag_d[j]} : t1;
		assign t2  = {r1[31:0], num_d[j][NW-2-2*j]};
		assign ge2 = t2 >= {1'b0, mag_d[j]};
		assign r2  = ge2 ? t2 - {1'b0, mag_d[j]} : t2;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_d[j+1]  <= {quo_d[j][NW-3:0], ge1, ge2};
				neg_d[j+1]  <= neg_d[j];
				zero_d[j+1] <= zero_d[j];
			end
		end

		if (j < STEPS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_d[j+1] <= r2[31:0];
					num_d[j+1] <= num_d[j];
					mag_d[j+1] <= mag_d[j];
				end
			end
		end
	end

	// Apply sign and saturate; a zero scale gives the largest positive value
	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_d[STEPS]) begin
				inv_r <= 32'sh7FFF_FFFF;
			end else if (neg_d[STEPS]) begin
				inv_r <= (quo_d[STEPS] > NW'(64'h8000_0000)) ? 32'sh8000_0000
				                                             : -$signed(quo_d[STEPS][31:0]);
			end else begin
				inv_r <= (quo_d[STEPS] > NW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
				                                             : $signed(quo_d[STEPS][31:0]);
			end
		end
	end

	// Pad to the common unit latency
	if (PAD > 0) begin : g_pad
		logic signed [31:0] inv_p [PAD];

		always_ff @(posedge clk) begin
			if (en) begin
				inv_p[0] <= inv_r;
				for (int i = 1; i < PAD; i++) begin
					inv_p[i] <= inv_p[i-1];
				end
			end
		end

		assign inv = inv_p[PAD-1];
	end else begin : g_nopad
		assign inv = inv_r;
	end

endmodule

`default_nettype wire

// File: sv/euler_scale_transform_matrix_unit.sv
`default_nettype none

// Y-X-Z Euler rotation with per-axis scale and translation. Each request on the
// slave side carries one object; the block answers with seven columns on the
// master side: model columns 0..3 (the fourth is the translation), then normal
// columns 0..2, the last one flagged by tlast. All values are signed Q16.16,
// angles are 16-bit binary angles. The pipeline is 26 stages deep (22 for the
// Taylor sine/cosine and the reciprocal divider, four for the matrix products)
// and takes a new object in any cycle it has room. The single result channel
// moves one column per cycle while m_tready is high.
module euler_scale_transform_matrix_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// angle_x, angle_y, angle_z, scale_x, scale_y, scale_z, offset_x, offset_y, offset_z
	input  logic [esm_pkg::IN_W-1:0]     s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// entry_0, entry_1, entry_2
	output logic [esm_pkg::OUT_W-1:0]    m_tdata,
	// matrix_select, column_index, zero_scale_fault
	output logic [esm_pkg::USER_W-1:0]   m_tuser,
	output logic                         m_tlast
);

	localparam int PL = esm_pkg::PIPE_LAT;
	localparam int SL = esm_pkg::SIDE_LAT;

	logic [15:0] angle_x;
	logic [15:0] angle_y;
	logic [15:0] angle_z;
	esm_pkg::side_t side_in;

	logic          en;
	logic          free;
	logic [PL-1:0] v_q;

	esm_pkg::side_t side_q [SL];

	logic signed [31:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;
	logic signed [31:0] inv_x, inv_y, inv_z;
	logic signed [31:0] inv_s1 [3];
	logic signed [31:0] inv_s2 [3];
	logic signed [31:0] inv_s3 [3];

	logic signed [31:0] a_s1, b_s1, cycz_s1, cxsz_s1, czsy_s1, cysz_s1;
	logic signed [31:0] cxcz_s1, sysz_s1, cxsy_s1, cycx_s1, sz_s1, cz_s1, sx_s1;
	logic signed [31:0] asz_s2, bsz_s2, acz_s2, bcz_s2;
	logic signed [31:0] cycz_s2, cxsz_s2, czsy_s2, cysz_s2, cxcz_s2, sysz_s2;
	logic signed [31:0] cxsy_s2, cycx_s2, sx_s2;
	logic signed [32:0] rot_s3 [3][3];

	esm_pkg::colset_t cols_s4;
	esm_pkg::colset_t hold_q;
	logic             hold_v_q;
	logic [esm_pkg::BEAT_W-1:0] beat_q;

	logic [2:0][31:0] ent;
	logic             sel;
	logic [1:0]       col;

	// Unpack the request
	assign angle_x = s_tdata[15:0];
	assign angle_y = s_tdata[31:16];
	assign angle_z = s_tdata[47:32];
	assign side_in.scale  = s_tdata[143:48];
	assign side_in.offset = s_tdata[239:144];
	assign side_in.fault  = (s_tdata[79:48] == 32'd0) || (s_tdata[111:80] == 32'd0) ||
	                        (s_tdata[143:112] == 32'd0);

	// Advance the whole pipeline unless the last stage is blocked
	assign free     = !hold_v_q || (m_tready && beat_q == esm_pkg::BEAT_LAST);
	assign en       = !v_q[PL-1] || free;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[PL-2:0], s_tvalid};
		end
	end

	// Carry scale, translation and fault beside the trig units
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_in;
			for (int i = 1; i < SL; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	esm_sincos u_trig_x (.clk(clk), .en(en), .angle(angle_x[esm_pkg::ANGLE_BITS-1:0]),
		.sin_val(sin_x), .cos_val(cos_x));
	esm_sincos u_trig_y (.clk(clk), .en(en), .angle(angle_y[esm_pkg::ANGLE_BITS-1:0]),
		.sin_val(sin_y), .cos_val(cos_y));
	esm_sincos u_trig_z (.clk(clk), .en(en), .angle(angle_z[esm_pkg::ANGLE_BITS-1:0]),
		.sin_val(sin_z), .cos_val(cos_z));

	esm_rcp u_rcp_x (.clk(clk), .en(en), .scale($signed(s_tdata[79:48])), .inv(inv_x));
	esm_rcp u_rcp_y (.clk(clk), .en(en), .scale($signed(s_tdata[111:80])), .inv(inv_y));
	esm_rcp u_rcp_z (.clk(clk), .en(en), .scale($signed(s_tdata[143:112])), .inv(inv_z));

	// Stage 1: pair products
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= 32'(esm_pkg::mul30(33'(sin_y), 33'(sin_x)));
			b_s1    <= 32'(esm_pkg::mul30(33'(cos_y), 33'(sin_x)));
			cycz_s1 <= 32'(esm_pkg::mul30(33'(cos_y), 33'(cos_z)));
			cxsz_s1 <= 32'(esm_pkg::mul30(33'(cos_x), 33'(sin_z)));
			czsy_s1 <= 32'(esm_pkg::mul30(33'(cos_z), 33'(sin_y)));
			cysz_s1 <= 32'(esm_pkg::mul30(33'(cos_y), 33'(sin_z)));
			cxcz_s1 <= 32'(esm_pkg::mul30(33'(cos_x), 33'(cos_z)));
			sysz_s1 <= 32'(esm_pkg::mul30(33'(sin_y), 33'(sin_z)));
			cxsy_s1 <= 32'(esm_pkg::mul30(33'(cos_x), 33'(sin_y)));
			cycx_s1 <= 32'(esm_pkg::mul30(33'(cos_y), 33'(cos_x)));
			sz_s1   <= sin_z;
			cz_s1   <= cos_z;
			sx_s1   <= sin_x;
			inv_s1[0] <= inv_x;
			inv_s1[1] <= inv_y;
			inv_s1[2] <= inv_z;
		end
	end

	// Stage 2: three-factor products
	always_ff @(posedge clk) begin
		if (en) begin
			asz_s2  <= 32'(esm_pkg::mul30(33'(a_s1), 33'(sz_s1)));
			bsz_s2  <= 32'(esm_pkg::mul30(33'(b_s1), 33'(sz_s1)));
			acz_s2  <= 32'(esm_pkg::mul30(33'(a_s1), 33'(cz_s1)));
			bcz_s2  <= 32'(esm_pkg::mul30(33'(b_s1), 33'(cz_s1)));
			cycz_s2 <= cycz_s1;
			cxsz_s2 <= cxsz_s1;
			czsy_s2 <= czsy_s1;
			cysz_s2 <= cysz_s1;
			cxcz_s2 <= cxcz_s1;
			sysz_s2 <= sysz_s1;
			cxsy_s2 <= cxsy_s1;
			cycx_s2 <= cycx_s1;
			sx_s2   <= sx_s1;
			inv_s2  <= inv_s1;
		end
	end

	// Stage 3: rotation entries
	always_ff @(posedge clk) begin
		if (en) begin
			rot_s3[0][0] <= 33'(cycz_s2) + 33'(asz_s2);
			rot_s3[0][1] <= 33'(cxsz_s2);
			rot_s3[0][2] <= 33'(bsz_s2) - 33'(czsy_s2);
			rot_s3[1][0] <= 33'(acz_s2) - 33'(cysz_s2);
			rot_s3[1][1] <= 33'(cxcz_s2);
			rot_s3[1][2] <= 33'(bcz_s2) + 33'(sysz_s2);
			rot_s3[2][0] <= 33'(cxsy_s2);
			rot_s3[2][1] <= -33'(sx_s2);
			rot_s3[2][2] <= 33'(cycx_s2);
			inv_s3       <= inv_s2;
		end
	end

	// Stage 4: scale and reciprocal products, saturated
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					cols_s4.model[c][r] <= esm_pkg::sat32(esm_pkg::mul30(
						33'($signed(side_q[SL-1].scale[c])), rot_s3[c][r]));
					cols_s4.normal[c][r] <= esm_pkg::sat32(esm_pkg::mul30(
						33'(inv_s3[c]), rot_s3[c][r]));
				end
			end
			cols_s4.offset <= side_q[SL-1].offset;
			cols_s4.fault  <= side_q[SL-1].fault;
		end
	end

	// Column output: hold one object and step through its seven columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			beat_q   <= esm_pkg::BEAT_FIRST;
		end else if (free) begin
			hold_v_q <= v_q[PL-1];
			beat_q   <= esm_pkg::BEAT_FIRST;
		end else if (m_tready) begin
			beat_q <= beat_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (free && v_q[PL-1]) begin
			hold_q <= cols_s4;
		end
	end

	// Select the column for the current beat
	always_comb begin
		ent = hold_q.offset;
		sel = 1'b0;
		col = beat_q[1:0];
		if (beat_q < esm_pkg::BEAT_OFFSET) begin
			ent = hold_q.model[beat_q[1:0]];
		end else if (beat_q >= esm_pkg::BEAT_NORMAL) begin
			sel = 1'b1;
			col = 2'(beat_q - esm_pkg::BEAT_NORMAL);
			ent = hold_q.normal[col];
		end
	end

	assign m_tvalid = hold_v_q;
	assign m_tdata  = ent;
	assign m_tuser  = {hold_q.fault, col, sel};
	assign m_tlast  = (beat_q == esm_pkg::BEAT_LAST);

`ifndef NO_ASSERTIONS
	a_beat_step: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q && m_tready && !m_tlast |=> hold_v_q && beat_q == $past(beat_q) + 3'd1)
		else $error("column beat did not advance after a taken column");

	a_beat_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q && !m_tready |=> hold_v_q && $stable(beat_q) && $stable(m_tuser))
		else $error("column output changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v_q[PL-1] && hold_v_q && !(m_tready && m_tlast))
		else $error("pipeline stalled without a blocked output");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		free && hold_v_q |-> m_tready && m_tlast)
		else $error("held object replaced before its last column was taken");
`endif

endmodule

`default_nettype wire

// File: sim/euler_scale_transform_matrix_unit_tb.sv
`default_nettype none

module euler_scale_transform_matrix_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_RANDOM  = 310;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [31:0] offset_z;
		logic [31:0] offset_y;
		logic [31:0] offset_x;
		logic [31:0] scale_z;
		logic [31:0] scale_y;
		logic [31:0] scale_x;
		logic [15:0] angle_z;
		logic [15:0] angle_y;
		logic [15:0] angle_x;
	} object_t;

	typedef struct packed {
		logic        matrix_select;
		logic [1:0]  column_index;
		logic [31:0] entry_0;
		logic [31:0] entry_1;
		logic [31:0] entry_2;
		logic        zero_scale_fault;
		logic        last;
	} column_t;

	// Directed rows; a checked row also carries hand-written first column
	typedef struct {
		object_t     obj;
		bit          typed;
		logic [31:0] col0_e0;
		logic [31:0] col0_e1;
		logic [31:0] col0_e2;
	} row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [esm_pkg::IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [esm_pkg::OUT_W-1:0] m_tdata;
	logic [esm_pkg::USER_W-1:0] m_tuser;
	logic m_tlast;

	column_t expected_columns[$];
	row_t    directed_rows[$];
	int      fail_count;
	int      cycle_count;
	bit      stimulus_done;
	bit      hold_sink;

	euler_scale_transform_matrix_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Round to nearest with ties away from zero, drop 30 fraction bits
	function automatic longint round30(input longint p);
		longint mag;
		mag = (p < 0) ? -p : p;
		mag = (mag + (64'sd1 <<< 29)) >>> 30;
		return (p < 0) ? -mag : mag;
	endfunction

	function automatic longint q30_mul(input longint a, input longint b);
		return round30(a * b);
	endfunction

	function automatic logic [31:0] clip32(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'h7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// Taylor sine/cosine on a folded octant, then octant symmetry
	task automatic angle_to_sincos(input logic [15:0] angle, output longint s_o,
		output longint c_o);
		logic [31:0] turn;
		logic [2:0]  octant;
		longint unsigned r, x, x2, term;
		longint s, c, sv, cv;
		turn = {angle, 16'h0};
		octant = turn[31:29];
		r = turn[28:0];
		if (octant[0]) begin
			r = (64'd1 << 29) - r;
		end
		x = (r * 64'd3373259426 + (64'd1 << 30)) >> 31;
		x2 = (x * x + (64'd1 << 29)) >> 30;
		term = x;
		s = x;
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2 + (64'd1 << 29)) >> 30) / ((2 * k) * (2 * k + 1));
			s = (k % 2) ? s - longint'(term) : s + longint'(term);
		end
		term = 64'd1 << 30;
		c = 64'sd1 <<< 30;
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2 + (64'd1 << 29)) >> 30) / ((2 * k - 1) * (2 * k));
			c = (k % 2) ? c - longint'(term) : c + longint'(term);
		end
		if (s < 0) s = 0;
		if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
		if (c < 0) c = 0;
		if (c > (64'sd1 <<< 30)) c = 64'sd1 <<< 30;
		sv = s;
		cv = c;
		if (octant == 1 || octant == 2 || octant == 5 || octant == 6) begin
			sv = c;
			cv = s;
		end
		if (octant >= 4) sv = -sv;
		if (octant >= 2 && octant <= 5) cv = -cv;
		s_o = sv;
		c_o = cv;
	endtask

	function automatic longint inverse_scale(input longint s);
		longint unsigned mag, q;
		if (s == 0) begin
			return 64'sd2147483647;
		end
		mag = (s < 0) ? -s : s;
		q = ((64'd1 << (2 * esm_pkg::FRAC_BITS)) + (mag >> 1)) / mag;
		if (s < 0) begin
			return (q > 64'h8000_0000) ? -64'sd2147483648 : -longint'(q);
		end
		return (q > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q);
	endfunction

	// Compute the seven columns of one object and queue them
	task automatic predict_columns(input object_t o);
		longint s1, c1, s2, c2, s3, c3, a, b;
		longint rot[3][3];
		longint scl[3], inv[3];
		logic   fault;
		column_t col;
		angle_to_sincos(o.angle_y, s1, c1);
		angle_to_sincos(o.angle_x, s2, c2);
		angle_to_sincos(o.angle_z, s3, c3);
		a = q30_mul(s1, s2);
		b = q30_mul(c1, s2);
		rot[0][0] = q30_mul(c1, c3) + q30_mul(a, s3);
		rot[0][1] = q30_mul(c2, s3);
		rot[0][2] = q30_mul(b, s3) - q30_mul(c3, s1);
		rot[1][0] = q30_mul(a, c3) - q30_mul(c1, s3);
		rot[1][1] = q30_mul(c2, c3);
		rot[1][2] = q30_mul(b, c3) + q30_mul(s1, s3);
		rot[2][0] = q30_mul(c2, s1);
		rot[2][1] = -s2;
		rot[2][2] = q30_mul(c1, c2);
		scl[0] = longint'($signed(o.scale_x));
		scl[1] = longint'($signed(o.scale_y));
		scl[2] = longint'($signed(o.scale_z));
		fault = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (scl[i] == 0) fault = 1'b1;
			inv[i] = inverse_scale(scl[i]);
		end
		for (int k = 0; k < 7; k++) begin
			col.matrix_select = (k >= 4);
			col.column_index = (k >= 4) ? 2'(k - 4) : 2'(k);
			col.zero_scale_fault = fault;
			col.last = (k == 6);
			if (k == 3) begin
				col.entry_0 = o.offset_x;
				col.entry_1 = o.offset_y;
				col.entry_2 = o.offset_z;
			end else if (k < 3) begin
				col.entry_0 = clip32(q30_mul(scl[k], rot[k][0]));
				col.entry_1 = clip32(q30_mul(scl[k], rot[k][1]));
				col.entry_2 = clip32(q30_mul(scl[k], rot[k][2]));
			end else begin
				col.entry_0 = clip32(q30_mul(inv[k-4], rot[k-4][0]));
				col.entry_1 = clip32(q30_mul(inv[k-4], rot[k-4][1]));
				col.entry_2 = clip32(q30_mul(inv[k-4], rot[k-4][2]));
			end
			expected_columns.push_back(col);
		end
	endtask

	function automatic object_t make_object(input logic [15:0] ax, input logic [15:0] ay,
		input logic [15:0] az, input logic [31:0] sx, input logic [31:0] sy,
		input logic [31:0] sz, input logic [31:0] ox, input logic [31:0] oy,
		input logic [31:0] oz);
		object_t o;
		o.angle_x = ax;
		o.angle_y = ay;
		o.angle_z = az;
		o.scale_x = sx;
		o.scale_y = sy;
		o.scale_z = sz;
		o.offset_x = ox;
		o.offset_y = oy;
		o.offset_z = oz;
		return o;
	endfunction

	function automatic logic [31:0] random_scale();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return $urandom();
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'($signed($urandom_range(0, 6)) - 3);
			default: return 32'($signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
		endcase
	endfunction

	function automatic object_t random_object();
		return make_object($urandom(), $urandom(), $urandom(), random_scale(),
			random_scale(), random_scale(), $urandom(), $urandom(), $urandom());
	endfunction

	// Offer one request after the given gap; valid stays high when no gap follows
	task automatic send_object(input object_t o, input int gap);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= esm_pkg::IN_W'(o);
		predict_columns(o);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic build_rows();
		row_t r;
		r.typed = 1'b0;
		// Identity: column 0 is the x scale along the first row
		r.obj = make_object(16'h0, 16'h0, 16'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		r.typed = 1'b1;
		r.col0_e0 = 32'h1_0000;
		r.col0_e1 = 32'h0;
		r.col0_e2 = 32'h0;
		directed_rows.push_back(r);
		// Zero scale: model entries vanish, fault raised
		r.obj = make_object(16'h0, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
		r.col0_e0 = 32'h0;
		directed_rows.push_back(r);
		r.typed = 1'b0;
		for (int i = 0; i < 8; i++) begin
			r.obj = make_object(16'(i * 16'h2000), 16'(i * 16'h2000 + 16'h1000),
				16'hFFFF - 16'(i), 32'h1_0000, 32'h2_0000, 32'h0_8000, 32'(i), 32'(-i), 32'h1);
			directed_rows.push_back(r);
		end
		// Saturating scales and reciprocals
		r.obj = make_object(16'hFFFF, 16'h4000, 16'h8000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h1, 32'h0, 32'h0, 32'h0);
		directed_rows.push_back(r);
		r.obj = make_object(16'h1FFF, 16'h6000, 16'hA000, 32'hFFFF_FFFF, 32'h2, 32'hFFFF_FFFE,
			32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_0000);
		directed_rows.push_back(r);
		r.obj = make_object(16'h2000, 16'hE000, 16'hC000, 32'hFFFF_0000, 32'h0, 32'h3_0000,
			32'h0, 32'h0, 32'h0);
		directed_rows.push_back(r);
	endtask

	// Sender: directed table, then random objects with a burst during the hold-off
	initial begin
		object_t o;
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		build_rows();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			send_object(directed_rows[i].obj, $urandom_range(0, 7));
			if (directed_rows[i].typed) begin
				expected_columns[expected_columns.size() - 7].entry_0 = directed_rows[i].col0_e0;
				expected_columns[expected_columns.size() - 7].entry_1 = directed_rows[i].col0_e1;
				expected_columns[expected_columns.size() - 7].entry_2 = directed_rows[i].col0_e2;
			end
		end
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (n == NUM_RANDOM / 2) begin
				hold_sink = 1'b1;
			end
			o = random_object();
			if (n > NUM_RANDOM / 2 && n < NUM_RANDOM / 2 + 20) begin
				send_object(o, 0);
			end else begin
				send_object(o, $urandom_range(0, 7));
			end
		end
		s_tvalid <= 1'b0;
		stimulus_done = 1'b1;
	end

	// Receiver: random stalls, one long hold-off in the middle
	initial begin
		int wait_cycles;
		m_tready = 1'b0;
		hold_sink = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_sink = 1'b0;
			end
			wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			if (wait_cycles != 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// Compare each accepted column with the oldest prediction
	always @(posedge clk) begin
		column_t want;
		if (m_tvalid && m_tready) begin
			if (expected_columns.size() == 0) begin
				$error("unexpected column: user=%h data=%h", m_tuser, m_tdata);
				fail_count++;
			end else begin
				want = expected_columns.pop_front();
				if (m_tdata[31:0] !== want.entry_0) begin
					$error("entry_0: expected %h, got %h", want.entry_0, m_tdata[31:0]);
					fail_count++;
				end
				if (m_tdata[63:32] !== want.entry_1) begin
					$error("entry_1: expected %h, got %h", want.entry_1, m_tdata[63:32]);
					fail_count++;
				end
				if (m_tdata[95:64] !== want.entry_2) begin
					$error("entry_2: expected %h, got %h", want.entry_2, m_tdata[95:64]);
					fail_count++;
				end
				if (m_tuser[0] !== want.matrix_select) begin
					$error("matrix_select: expected %0d, got %0d", want.matrix_select, m_tuser[0]);
					fail_count++;
				end
				if (m_tuser[2:1] !== want.column_index) begin
					$error("column_index: expected %0d, got %0d", want.column_index, m_tuser[2:1]);
					fail_count++;
				end
				if (m_tuser[3] !== want.zero_scale_fault) begin
					$error("zero_scale_fault: expected %0d, got %0d", want.zero_scale_fault,
						m_tuser[3]);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// End of run: drain, settle, report; or time out
	initial begin
		fail_count = 0;
		cycle_count = 0;
		stimulus_done = 1'b0;
		fork
			begin
				wait (stimulus_done);
				while (expected_columns.size() != 0) @(posedge clk);
				repeat (esm_pkg::PIPE_LAT + 10) @(posedge clk);
				if (fail_count == 0) begin
					$display("No mismatches found");
				end else begin
					$display("Mismatches found");
				end
			end
			begin
				while (cycle_count < CYCLE_LIMIT) begin
					@(posedge clk);
					cycle_count++;
				end
				$display("Mismatches found");
			end
		join_any
		$finish;
	end

endmodule

`default_nettype wire

// File: euler_scale_transform_matrix_unit.f
sv/esm_pkg.sv
sv/esm_sincos.sv
sv/esm_rcp.sv
sv/euler_scale_transform_matrix_unit.sv
sim/euler_scale_transform_matrix_unit_tb.sv
